// File: hw/rtl/multicore_task_dispatcher_assert.svh
// Assertion macros for the task dispatcher.
// Used by the top level; expects signals clk and rst in scope.
`ifndef MULTICORE_TASK_DISPATCHER_ASSERT_SVH
`define MULTICORE_TASK_DISPATCHER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MTD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dispatcher assertion failed");

// Next-cycle implication, disabled during reset.
`define MTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dispatcher assertion failed");

`endif

// File: hw/rtl/mtd_pkg.sv
// Shared constants, codes, types and helper functions of the task dispatcher.
// No dependencies.
package mtd_pkg;

  localparam int NUM_CORES   = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int TASK_BITS   = 16;

  localparam int CORE_W      = $clog2(NUM_CORES);
  localparam int NACT_W      = $clog2(NUM_CORES + 1);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int STORE_DEPTH = NUM_CORES * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CAP_W       = 6;
  localparam int CFG_W       = 3;
  localparam int OP_W        = 3;
  localparam int ST_W        = 4;
  localparam int CID_W       = 4;
  localparam int TID_W       = 16;
  localparam int REP_W       = 6;
  localparam int DPOP_W      = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);
  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);
  localparam logic [CAP_W-1:0] CAP_SAT   = CAP_W'(63);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SPAWN = 3'd0;
  localparam logic [OP_W-1:0] OP_RUN   = 3'd1;
  localparam logic [OP_W-1:0] OP_SLEEP = 3'd2;
  localparam logic [OP_W-1:0] OP_SHUT  = 3'd3;
  localparam logic [OP_W-1:0] OP_SIZE  = 3'd4;
  localparam logic [OP_W-1:0] OP_CAPQ  = 3'd5;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_FAIL        = 4'd0;
  localparam logic [ST_W-1:0] ST_ASSIGNED    = 4'd1;
  localparam logic [ST_W-1:0] ST_RUNNING     = 4'd2;
  localparam logic [ST_W-1:0] ST_NONE_RUN    = 4'd3;
  localparam logic [ST_W-1:0] ST_MOVED       = 4'd4;
  localparam logic [ST_W-1:0] ST_NONE_ASSIGN = 4'd5;
  localparam logic [ST_W-1:0] ST_DELETED     = 4'd6;
  localparam logic [ST_W-1:0] ST_NONE_REMOVE = 4'd7;
  localparam logic [ST_W-1:0] ST_SIZE        = 4'd8;
  localparam logic [ST_W-1:0] ST_CAP         = 4'd9;

  // Datapath commands.
  localparam logic [DPOP_W-1:0] DP_NONE       = 5'd0;
  localparam logic [DPOP_W-1:0] DP_LATCH      = 5'd1;
  localparam logic [DPOP_W-1:0] DP_PICK_SPAWN = 5'd2;
  localparam logic [DPOP_W-1:0] DP_PICK_DONOR = 5'd3;
  localparam logic [DPOP_W-1:0] DP_PICK_SLEEP = 5'd4;
  localparam logic [DPOP_W-1:0] DP_RD_FRONT   = 5'd5;
  localparam logic [DPOP_W-1:0] DP_RD_DONOR   = 5'd6;
  localparam logic [DPOP_W-1:0] DP_RD_SCAN    = 5'd7;
  localparam logic [DPOP_W-1:0] DP_PUSH_TASK  = 5'd8;
  localparam logic [DPOP_W-1:0] DP_RULE_TGT   = 5'd9;
  localparam logic [DPOP_W-1:0] DP_RULE_CORE  = 5'd10;
  localparam logic [DPOP_W-1:0] DP_POP_FRONT  = 5'd11;
  localparam logic [DPOP_W-1:0] DP_STEAL_MOVE = 5'd12;
  localparam logic [DPOP_W-1:0] DP_SLEEP_MOVE = 5'd13;
  localparam logic [DPOP_W-1:0] DP_SHUT_START = 5'd14;
  localparam logic [DPOP_W-1:0] DP_SHUT_NEXT  = 5'd15;
  localparam logic [DPOP_W-1:0] DP_SHUT_CORE  = 5'd16;
  localparam logic [DPOP_W-1:0] DP_SHUT_CLEAR = 5'd17;

  typedef struct packed {
    logic [DPOP_W-1:0] op;
    logic              emit;
    logic [ST_W-1:0]   status;
    logic              last;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            core_bad;
    logic            core_empty;
    logic            core_one;
    logic            nact_lt2;
    logic            any_tasks;
    logic            spawn_fail;
    logic            donor_ok;
    logic            tgt_full;
    logic            scan_done;
    logic            scan_last_core;
    logic            scan_last_item;
    logic            out_free;
  } dp_stat_t;

  // Number of cores in use: zero acts as one, too large acts as the maximum.
  function automatic logic [NACT_W-1:0] cores_in_use(input logic [CFG_W-1:0] a);
    logic [NACT_W-1:0] n;
    if (a == '0) begin
      n = NACT_W'(1);
    end else if (int'(a) > NUM_CORES) begin
      n = NACT_W'(NUM_CORES);
    end else begin
      n = NACT_W'(a);
    end
    return n;
  endfunction

  // Grow and shrink rule for the nominal capacity of one queue.
  function automatic logic [CAP_W-1:0] apply_rule(input logic [CNT_W-1:0] cnt,
                                                  input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] r;
    r = cap;
    if (cnt == '0) begin
      r = CAP_MIN;
    end else if (int'(cap) == int'(cnt)) begin
      r = (cap >= CAP_W'(32)) ? CAP_SAT : {cap[CAP_W-2:0], 1'b0};
    end else if ((int'(cnt) <= int'(cap >> 2)) && (cap > CAP_MIN)) begin
      r = cap >> 1;
      if (r < CAP_MIN) begin
        r = CAP_MIN;
      end
    end
    return r;
  endfunction

  // Ring pointer plus offset; the sum stays below twice the depth.
  function automatic logic [PTR_W-1:0] ring(input logic [PTR_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (int'(s) >= QUEUE_DEPTH) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return PTR_W'(s);
  endfunction

  function automatic logic [ADDR_W-1:0] slot(input logic [CORE_W-1:0] core,
                                             input logic [PTR_W-1:0] ptr);
    return ADDR_W'(int'(core) * QUEUE_DEPTH + int'(ptr));
  endfunction

endpackage

// File: hw/rtl/mtd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/mtd_datapath.sv
// Datapath of the task dispatcher: queue counters, capacities, ring heads,
// the task store and the result register. Depends on mtd_pkg and mtd_ram.
module mtd_datapath import mtd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic [OP_W-1:0]  operation,
  input  logic [TID_W-1:0] task_id,
  input  logic [CID_W-1:0] core_id,
  input  logic             out_stall,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output logic             out_valid,
  output logic [ST_W-1:0]  status,
  output logic [CID_W-1:0] core_number,
  output logic [TID_W-1:0] task_number,
  output logic [REP_W-1:0] report_value,
  output logic             last
);

  logic [CFG_W-1:0]     active_cores;
  logic [CNT_W-1:0]     cnt  [NUM_CORES];
  logic [CAP_W-1:0]     cap  [NUM_CORES];
  logic [PTR_W-1:0]     head [NUM_CORES];
  logic [OP_W-1:0]      op_r;
  logic [TASK_BITS-1:0] task_r;
  logic [CID_W-1:0]     core_r;
  logic [NACT_W-1:0]    nact;
  logic [CORE_W-1:0]    tgt;
  logic [CNT_W-1:0]     kidx;
  logic                 donor_found;
  logic [ADDR_W-1:0]    rd_addr;

  logic [CORE_W-1:0]    cidx;
  logic [CORE_W-1:0]    spawn_sel;
  logic [CORE_W-1:0]    sleep_sel;
  logic [CORE_W-1:0]    donor_sel;
  logic                 donor_any;
  logic                 later_busy;
  logic                 any_busy;
  logic                 out_free;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [TASK_BITS-1:0] ram_wdata;
  logic [TASK_BITS-1:0] rdata;
  logic [CID_W-1:0]     core_out;
  logic [TID_W-1:0]     task_out;
  logic [REP_W-1:0]     rep_out;

  assign cidx     = CORE_W'(core_r);
  assign out_free = !out_valid || !out_stall;

  // Core selection scans: least loaded for spawn and sleep, fullest for steal.
  always_comb begin
    logic [CNT_W-1:0] most;
    spawn_sel  = '0;
    sleep_sel  = (cidx == '0) ? CORE_W'(1) : '0;
    donor_sel  = '0;
    donor_any  = 1'b0;
    most       = '0;
    later_busy = 1'b0;
    any_busy   = 1'b0;
    for (int i = 0; i < NUM_CORES; i++) begin
      if (i < int'(nact)) begin
        any_busy = any_busy || (cnt[i] != '0);
        if (cnt[i] < cnt[spawn_sel]) begin
          spawn_sel = CORE_W'(i);
        end
        if (i != int'(cidx) && cnt[i] < cnt[sleep_sel]) begin
          sleep_sel = CORE_W'(i);
        end
        if (i != int'(cidx) && cnt[i] > most) begin
          most      = cnt[i];
          donor_sel = CORE_W'(i);
          donor_any = 1'b1;
        end
        if (i > int'(tgt) && cnt[i] != '0) begin
          later_busy = 1'b1;
        end
      end
    end
  end

  always_comb begin
    stat.op             = op_r;
    stat.core_bad       = int'(core_r) >= int'(nact);
    stat.core_empty     = cnt[cidx] == '0;
    stat.core_one       = cnt[cidx] == CNT_W'(1);
    stat.nact_lt2       = nact < NACT_W'(2);
    stat.any_tasks      = any_busy;
    stat.spawn_fail     = (task_r == '0) || (int'(cnt[tgt]) >= QUEUE_DEPTH);
    stat.donor_ok       = donor_found && (int'(cnt[cidx]) < QUEUE_DEPTH);
    stat.tgt_full       = int'(cnt[tgt]) >= QUEUE_DEPTH;
    stat.scan_done      = kidx >= cnt[tgt];
    stat.scan_last_core = int'(tgt) == int'(nact) - 1;
    stat.scan_last_item = (kidx == cnt[tgt] - CNT_W'(1)) && !later_busy;
    stat.out_free       = out_free;
  end

  // Store writes: new tasks and moved tasks land at the tail of a queue.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot(tgt, ring(head[tgt], cnt[tgt]));
    ram_wdata = rdata;
    case (cmd.op)
      DP_PUSH_TASK: begin
        ram_we    = 1'b1;
        ram_wdata = task_r;
      end
      DP_SLEEP_MOVE: begin
        ram_we = 1'b1;
      end
      DP_STEAL_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = slot(cidx, ring(head[cidx], cnt[cidx]));
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  mtd_ram #(
    .WIDTH(TASK_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cores <= CFG_RESET;
      for (int i = 0; i < NUM_CORES; i++) begin
        cnt[i]  <= '0;
        cap[i]  <= CAP_RESET;
        head[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        active_cores <= cfg_data;
      end
      unique case (cmd.op)
        DP_PUSH_TASK: begin
          cap[tgt] <= apply_rule(cnt[tgt], cap[tgt]);
          cnt[tgt] <= cnt[tgt] + CNT_W'(1);
        end
        DP_RULE_TGT: begin
          cap[tgt] <= apply_rule(cnt[tgt], cap[tgt]);
        end
        DP_RULE_CORE: begin
          cap[cidx] <= apply_rule(cnt[cidx], cap[cidx]);
        end
        DP_POP_FRONT: begin
          head[cidx] <= ring(head[cidx], CNT_W'(1));
          cnt[cidx]  <= cnt[cidx] - CNT_W'(1);
        end
        DP_STEAL_MOVE: begin
          cnt[cidx] <= cnt[cidx] + CNT_W'(1);
          cnt[tgt]  <= cnt[tgt] - CNT_W'(1);
        end
        DP_SLEEP_MOVE: begin
          cap[tgt]  <= apply_rule(cnt[tgt], cap[tgt]);
          cnt[tgt]  <= cnt[tgt] + CNT_W'(1);
          cnt[cidx] <= cnt[cidx] - CNT_W'(1);
        end
        DP_SHUT_CLEAR: begin
          for (int i = 0; i < NUM_CORES; i++) begin
            if (i < int'(nact)) begin
              cnt[i] <= '0;
              cap[i] <= CAP_MIN;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Operand and pointer registers; no reset needed.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LATCH: begin
        op_r   <= operation;
        task_r <= TASK_BITS'(task_id);
        core_r <= core_id;
        nact   <= cores_in_use(active_cores);
      end
      DP_PICK_SPAWN: begin
        tgt <= spawn_sel;
      end
      DP_PICK_DONOR: begin
        tgt         <= donor_sel;
        donor_found <= donor_any;
      end
      DP_PICK_SLEEP: begin
        tgt     <= sleep_sel;
        rd_addr <= slot(cidx, ring(head[cidx], cnt[cidx] - CNT_W'(1)));
      end
      DP_RD_FRONT: begin
        rd_addr <= slot(cidx, head[cidx]);
      end
      DP_RD_DONOR: begin
        rd_addr <= slot(tgt, ring(head[tgt], cnt[tgt] - CNT_W'(1)));
      end
      DP_RD_SCAN: begin
        rd_addr <= slot(tgt, ring(head[tgt], kidx));
      end
      DP_SHUT_START: begin
        tgt  <= '0;
        kidx <= '0;
      end
      DP_SHUT_NEXT: begin
        kidx <= kidx + CNT_W'(1);
      end
      DP_SHUT_CORE: begin
        tgt  <= tgt + CORE_W'(1);
        kidx <= '0;
      end
      default: begin
      end
    endcase
  end

  // Result fields follow from the status code.
  always_comb begin
    core_out = core_r;
    task_out = '0;
    rep_out  = '0;
    case (cmd.status)
      ST_ASSIGNED: begin
        core_out = CID_W'(tgt);
        task_out = TID_W'(task_r);
      end
      ST_RUNNING: begin
        task_out = TID_W'(rdata);
      end
      ST_MOVED, ST_DELETED: begin
        core_out = CID_W'(tgt);
        task_out = TID_W'(rdata);
      end
      ST_NONE_REMOVE: begin
        core_out = '0;
      end
      ST_FAIL: begin
        if (op_r == OP_SPAWN || op_r > OP_CAPQ) begin
          core_out = '0;
        end
      end
      ST_SIZE: begin
        rep_out = REP_W'(cnt[cidx]);
      end
      ST_CAP: begin
        rep_out = REP_W'(cap[cidx]);
      end
      default: begin
        core_out = core_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status       <= cmd.status;
      core_number  <= core_out;
      task_number  <= task_out;
      report_value <= rep_out;
      last         <= cmd.last;
    end
  end

endmodule

// File: hw/rtl/mtd_ctrl.sv
// Controller state machine of the task dispatcher: sequences the datapath
// for each operation. Depends on mtd_pkg.
module mtd_ctrl import mtd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE        = 5'd0;
  localparam logic [4:0] S_DECODE      = 5'd1;
  localparam logic [4:0] S_ONE         = 5'd2;
  localparam logic [4:0] S_SPAWN_CHK   = 5'd3;
  localparam logic [4:0] S_SPAWN_RULE  = 5'd4;
  localparam logic [4:0] S_RUN_NONE    = 5'd5;
  localparam logic [4:0] S_RUN_WAIT    = 5'd6;
  localparam logic [4:0] S_RUN_EMIT    = 5'd7;
  localparam logic [4:0] S_STEAL_PICK  = 5'd8;
  localparam logic [4:0] S_STEAL_CHK   = 5'd9;
  localparam logic [4:0] S_STEAL_WAIT  = 5'd10;
  localparam logic [4:0] S_STEAL_MOVE  = 5'd11;
  localparam logic [4:0] S_STEAL_RD    = 5'd12;
  localparam logic [4:0] S_STEAL_RC    = 5'd13;
  localparam logic [4:0] S_SLP_PICK    = 5'd14;
  localparam logic [4:0] S_SLP_WAIT    = 5'd15;
  localparam logic [4:0] S_SLP_MOVE    = 5'd16;
  localparam logic [4:0] S_SLP_RULE    = 5'd17;
  localparam logic [4:0] S_SHUT_SCAN   = 5'd18;
  localparam logic [4:0] S_SHUT_WAIT   = 5'd19;
  localparam logic [4:0] S_SHUT_EMIT   = 5'd20;
  localparam logic [4:0] S_SHUT_CLEAR  = 5'd21;

  logic [4:0]      state;
  logic [4:0]      state_next;
  logic [ST_W-1:0] one_status;
  logic [ST_W-1:0] one_status_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next      = state;
    one_status_next = one_status;
    cmd.op          = DP_NONE;
    cmd.emit        = 1'b0;
    cmd.status      = one_status;
    cmd.last        = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next      = S_ONE;
        one_status_next = ST_FAIL;
        unique case (stat.op)
          OP_SPAWN: begin
            cmd.op     = DP_PICK_SPAWN;
            state_next = S_SPAWN_CHK;
          end
          OP_RUN: begin
            if (!stat.core_bad) begin
              if (stat.core_empty) begin
                state_next = S_RUN_NONE;
              end else begin
                cmd.op     = DP_RD_FRONT;
                state_next = S_RUN_WAIT;
              end
            end
          end
          OP_SLEEP: begin
            if (!stat.core_bad) begin
              if (stat.core_empty) begin
                one_status_next = ST_NONE_ASSIGN;
              end else if (!stat.nact_lt2) begin
                state_next = S_SLP_PICK;
              end
            end
          end
          OP_SHUT: begin
            if (stat.any_tasks) begin
              cmd.op     = DP_SHUT_START;
              state_next = S_SHUT_SCAN;
            end else begin
              one_status_next = ST_NONE_REMOVE;
            end
          end
          OP_SIZE, OP_CAPQ: begin
            if (!stat.core_bad) begin
              one_status_next = (stat.op == OP_SIZE) ? ST_SIZE : ST_CAP;
            end
          end
          default: begin
            one_status_next = ST_FAIL;
          end
        endcase
      end
      S_ONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SPAWN_CHK: begin
        if (stat.spawn_fail) begin
          one_status_next = ST_FAIL;
          state_next      = S_ONE;
        end else begin
          cmd.op     = DP_PUSH_TASK;
          state_next = S_SPAWN_RULE;
        end
      end
      S_SPAWN_RULE: begin
        cmd.op          = DP_RULE_TGT;
        one_status_next = ST_ASSIGNED;
        state_next      = S_ONE;
      end
      S_RUN_NONE: begin
        cmd.status = ST_NONE_RUN;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_STEAL_PICK;
        end
      end
      S_RUN_WAIT: begin
        state_next = S_RUN_EMIT;
      end
      S_RUN_EMIT: begin
        cmd.status = ST_RUNNING;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.op     = DP_POP_FRONT;
          state_next = stat.core_one ? S_STEAL_PICK : S_IDLE;
        end
      end
      S_STEAL_PICK: begin
        cmd.op     = DP_PICK_DONOR;
        state_next = S_STEAL_CHK;
      end
      S_STEAL_CHK: begin
        if (stat.donor_ok) begin
          cmd.op     = DP_RD_DONOR;
          state_next = S_STEAL_WAIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_STEAL_WAIT: begin
        state_next = S_STEAL_MOVE;
      end
      S_STEAL_MOVE: begin
        cmd.op     = DP_STEAL_MOVE;
        state_next = S_STEAL_RD;
      end
      S_STEAL_RD: begin
        cmd.op     = DP_RULE_TGT;
        state_next = S_STEAL_RC;
      end
      S_STEAL_RC: begin
        cmd.op     = DP_RULE_CORE;
        state_next = S_IDLE;
      end
      S_SLP_PICK: begin
        cmd.op     = DP_PICK_SLEEP;
        state_next = S_SLP_WAIT;
      end
      S_SLP_WAIT: begin
        state_next = S_SLP_MOVE;
      end
      S_SLP_MOVE: begin
        if (stat.tgt_full) begin
          cmd.status = ST_FAIL;
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_SLP_RULE;
          end
        end else begin
          cmd.status = ST_MOVED;
          cmd.last   = stat.core_one;
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.op     = DP_SLEEP_MOVE;
            state_next = stat.core_one ? S_SLP_RULE : S_SLP_PICK;
          end
        end
      end
      S_SLP_RULE: begin
        cmd.op     = DP_RULE_CORE;
        state_next = S_IDLE;
      end
      S_SHUT_SCAN: begin
        if (stat.scan_done) begin
          if (stat.scan_last_core) begin
            state_next = S_SHUT_CLEAR;
          end else begin
            cmd.op = DP_SHUT_CORE;
          end
        end else begin
          cmd.op     = DP_RD_SCAN;
          state_next = S_SHUT_WAIT;
        end
      end
      S_SHUT_WAIT: begin
        state_next = S_SHUT_EMIT;
      end
      S_SHUT_EMIT: begin
        cmd.status = ST_DELETED;
        cmd.last   = stat.scan_last_item;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.op     = DP_SHUT_NEXT;
          state_next = S_SHUT_SCAN;
        end
      end
      S_SHUT_CLEAR: begin
        cmd.op     = DP_SHUT_CLEAR;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      one_status <= ST_FAIL;
    end else begin
      state      <= state_next;
      one_status <= one_status_next;
    end
  end

endmodule

// File: hw/rtl/multicore_task_dispatcher.sv
// Top level of the task dispatcher: joins the controller and the datapath.
// Depends on mtd_pkg, mtd_ctrl, mtd_datapath and the assertion macro header.
//
// Usage: an operation (operation, task_id, core_id) transfers when in_valid
// is high and in_stall is low. Each operation yields one or more results
// (status, core_number, task_number, report_value, last); last marks the
// final result of an operation. A result transfers when out_valid is high and
// out_stall is low. The active core count is written with cfg_write and
// cfg_data while the block is idle.
// The controller handles one operation at a time: in_stall stays high from
// the cycle after a transfer until the operation has finished.
// Each operation is accepted and decoded; queries and most failures then
// write their result. Spawn pushes the task to the least loaded core; run
// reads the front task and, if the core is or becomes empty, tries to steal
// one; sleep moves tasks one by one; shutdown deletes every queued task.
// The task store has one read port with registered read data.
// While out_stall is high with out_valid set, the result register holds and
// the controller waits before it writes the next result; the last result of
// an operation may still wait while the next operation is taken in.
// Synchronous reset empties all queues, sets capacities to four, the active
// core count to four and drops out_valid.
`include "multicore_task_dispatcher_assert.svh"

module multicore_task_dispatcher import mtd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OP_W-1:0]  operation,
  input  logic [TID_W-1:0] task_id,
  input  logic [CID_W-1:0] core_id,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ST_W-1:0]  status,
  output logic [CID_W-1:0] core_number,
  output logic [TID_W-1:0] task_number,
  output logic [REP_W-1:0] report_value,
  output logic             last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mtd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  mtd_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .operation   (operation),
    .task_id     (task_id),
    .core_id     (core_id),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .status      (status),
    .core_number (core_number),
    .task_number (task_number),
    .report_value(report_value),
    .last        (last)
  );

  `MTD_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
  `MTD_ASSERT_IMPL(a_fail_clean, out_valid && status == ST_FAIL, task_number == '0 && report_value == '0)
  `MTD_ASSERT_IMPL(a_size_bound, out_valid && status == ST_SIZE, int'(report_value) <= QUEUE_DEPTH)

endmodule

// File: tb/sv/multicore_task_dispatcher_test.sv
// Testbench for the multicore task dispatcher: directed and random operations
// checked against a behavioral dispatcher model held in a small scoreboard.
// Depends on mtd_pkg and the dispatcher RTL.
`timescale 1ns / 100ps

module multicore_task_dispatcher_test;
  import mtd_pkg::*;

  typedef struct {
    logic [ST_W-1:0]  st;
    logic [CID_W-1:0] core;
    logic [TID_W-1:0] tid;
    logic [REP_W-1:0] rep;
    logic             lst;
  } disp_result_t;

  class dispatch_board;
    int unsigned ncfg;
    int unsigned qlen[NUM_CORES];
    int unsigned cap[NUM_CORES];
    logic [TID_W-1:0] tasks[NUM_CORES][QUEUE_DEPTH];
    disp_result_t pending[$];
    int errors;

    function void clear();
      ncfg = 4;
      foreach (qlen[i]) begin
        qlen[i] = 0;
        cap[i] = 4;
      end
      pending.delete();
      errors = 0;
    endfunction

    function int unsigned live_cores();
      if (ncfg == 0) return 1;
      if (ncfg > NUM_CORES) return NUM_CORES;
      return ncfg;
    endfunction

    function void add(logic [ST_W-1:0] s, int unsigned c, logic [TID_W-1:0] t,
                      int unsigned r);
      disp_result_t e;
      e.st = s;
      e.core = CID_W'(c);
      e.tid = t;
      e.rep = REP_W'(r);
      e.lst = 1'b0;
      pending.push_back(e);
    endfunction

    function void resize(int unsigned c);
      if (qlen[c] == 0) begin
        cap[c] = 2;
      end else if (cap[c] == qlen[c]) begin
        cap[c] = (cap[c] * 2 > 63) ? 63 : cap[c] * 2;
      end else if (qlen[c] <= cap[c] / 4 && cap[c] > 2) begin
        cap[c] = (cap[c] / 2 < 2) ? 2 : cap[c] / 2;
      end
    endfunction

    function void steal(int unsigned c, int unsigned n);
      int unsigned best, most;
      best = 0;
      most = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (i != c && qlen[i] > most) begin
          most = qlen[i];
          best = i;
        end
      end
      if (most == 0 || qlen[c] >= QUEUE_DEPTH) return;
      tasks[c][qlen[c]] = tasks[best][qlen[best] - 1];
      qlen[c]++;
      qlen[best]--;
      resize(best);
      resize(c);
    endfunction

    // Works out every result of one accepted operation.
    function void note_operation(logic [OP_W-1:0] op, logic [TID_W-1:0] tid,
                                 logic [CID_W-1:0] cid);
      int unsigned n, c, sel, tgt, moves, base;
      logic [TID_W-1:0] mv;
      bit any;
      n = live_cores();
      c = cid;
      base = pending.size();
      case (op)
        OP_SPAWN: begin
          sel = 0;
          for (int unsigned i = 1; i < n; i++) if (qlen[i] < qlen[sel]) sel = i;
          if (tid == 0 || qlen[sel] >= QUEUE_DEPTH) begin
            add(ST_FAIL, 0, 0, 0);
          end else begin
            resize(sel);
            tasks[sel][qlen[sel]] = tid;
            qlen[sel]++;
            resize(sel);
            add(ST_ASSIGNED, sel, tid, 0);
          end
        end
        OP_RUN: begin
          if (c >= n) begin
            add(ST_FAIL, c, 0, 0);
          end else if (qlen[c] == 0) begin
            add(ST_NONE_RUN, c, 0, 0);
            steal(c, n);
          end else begin
            add(ST_RUNNING, c, tasks[c][0], 0);
            for (int unsigned i = 0; i + 1 < qlen[c]; i++) tasks[c][i] = tasks[c][i + 1];
            qlen[c]--;
            if (qlen[c] == 0) steal(c, n);
          end
        end
        OP_SLEEP: begin
          if (c >= n) begin
            add(ST_FAIL, c, 0, 0);
          end else if (qlen[c] == 0) begin
            add(ST_NONE_ASSIGN, c, 0, 0);
          end else if (n < 2) begin
            add(ST_FAIL, c, 0, 0);
          end else begin
            moves = qlen[c];
            for (int unsigned k = 0; k < moves; k++) begin
              tgt = (c == 0) ? 1 : 0;
              for (int unsigned i = 0; i < n; i++)
                if (i != c && qlen[i] < qlen[tgt]) tgt = i;
              mv = tasks[c][qlen[c] - 1];
              if (qlen[tgt] >= QUEUE_DEPTH) begin
                add(ST_FAIL, c, 0, 0);
                break;
              end
              resize(tgt);
              tasks[tgt][qlen[tgt]] = mv;
              qlen[tgt]++;
              qlen[c]--;
              add(ST_MOVED, tgt, mv, 0);
            end
            resize(c);
          end
        end
        OP_SHUT: begin
          any = 0;
          for (int unsigned i = 0; i < n; i++) if (qlen[i] != 0) any = 1;
          if (!any) begin
            add(ST_NONE_REMOVE, 0, 0, 0);
          end else begin
            for (int unsigned i = 0; i < n; i++) begin
              for (int unsigned k = 0; k < qlen[i]; k++) add(ST_DELETED, i, tasks[i][k], 0);
              qlen[i] = 0;
              resize(i);
            end
          end
        end
        OP_SIZE, OP_CAPQ: begin
          if (c >= n) add(ST_FAIL, c, 0, 0);
          else if (op == OP_SIZE) add(ST_SIZE, c, 0, qlen[c]);
          else add(ST_CAP, c, 0, cap[c]);
        end
        default: add(ST_FAIL, 0, 0, 0);
      endcase
      if (pending.size() > base) pending[pending.size() - 1].lst = 1'b1;
    endfunction

    function void check_result(disp_result_t got);
      disp_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual st=%0d core=%0d task=%0d",
                 $time, got.st, got.core, got.tid);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.st !== e.st)
        $display("%0t: status expected %0d actual %0d", $time, e.st, got.st);
      if (got.core !== e.core)
        $display("%0t: core_number expected %0d actual %0d", $time, e.core, got.core);
      if (got.tid !== e.tid)
        $display("%0t: task_number expected %0d actual %0d", $time, e.tid, got.tid);
      if (got.rep !== e.rep)
        $display("%0t: report_value expected %0d actual %0d", $time, e.rep, got.rep);
      if (got.lst !== e.lst)
        $display("%0t: last expected %0d actual %0d", $time, e.lst, got.lst);
      if (got.st !== e.st || got.core !== e.core || got.tid !== e.tid ||
          got.rep !== e.rep || got.lst !== e.lst) errors++;
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [OP_W-1:0]  operation = '0;
  logic [TID_W-1:0] task_id = '0;
  logic [CID_W-1:0] core_id = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ST_W-1:0]  status;
  logic [CID_W-1:0] core_number;
  logic [TID_W-1:0] task_number;
  logic [REP_W-1:0] report_value;
  logic             last;

  dispatch_board board = new();
  int stall_mode = 0;

  multicore_task_dispatcher dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .task_id(task_id), .core_id(core_id), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .core_number(core_number),
    .task_number(task_number), .report_value(report_value), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall pattern; the mode changes between phases.
  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  always @(posedge clk) begin
    disp_result_t r;
    if (!rst && out_valid && !out_stall) begin
      r.st = status;
      r.core = core_number;
      r.tid = task_number;
      r.rep = report_value;
      r.lst = last;
      board.check_result(r);
    end
  end

  // One operation transfer; valid stays high when another follows at once.
  // When valid drops, the task returns only after the dispatcher has sampled it low.
  task automatic send_op(logic [OP_W-1:0] op, logic [TID_W-1:0] tid,
                         logic [CID_W-1:0] cid, bit keep);
    in_valid <= 1'b1;
    operation <= op;
    task_id <= tid;
    core_id <= cid;
    do @(posedge clk); while (in_stall);
    board.note_operation(op, tid, cid);
    if (!keep) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_cores(int unsigned n);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= CFG_W'(n);
    @(posedge clk);
    cfg_write <= 1'b0;
    board.ncfg = n;
  endtask

  task automatic random_ops(int count);
    int burst, r;
    logic [OP_W-1:0] op;
    logic [TID_W-1:0] tid;
    while (count > 0) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst && count > 0; b++) begin
        r = $urandom_range(0, 99);
        if (r < 45) op = OP_SPAWN;
        else if (r < 65) op = OP_RUN;
        else if (r < 73) op = OP_SLEEP;
        else if (r < 76) op = OP_SHUT;
        else if (r < 86) op = OP_SIZE;
        else if (r < 96) op = OP_CAPQ;
        else op = OP_W'($urandom_range(6, 7));
        tid = ($urandom_range(0, 30) == 0) ? '0 : TID_W'($urandom);
        count--;
        send_op(op, tid, CID_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                           : $urandom_range(0, 3)),
                (b + 1 < burst) && (count > 0));
      end
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
  endtask

  initial begin
    board.clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty queries, rejections, spawns, runs that steal, an empty sleep, shutdown.
    send_op(OP_SHUT, 0, 0, 0);
    send_op(OP_RUN, 0, 0, 0);
    send_op(OP_SLEEP, 0, 1, 0);
    send_op(OP_SIZE, 0, 15, 0);
    send_op(OP_CAPQ, 0, 3, 0);
    send_op(OP_SPAWN, 16'h0000, 0, 0);
    send_op(OP_SPAWN, 16'hFFFF, 0, 0);
    send_op(3'd6, 16'h1234, 0, 0);
    send_op(3'd7, 16'h1234, 0, 0);
    send_op(OP_SPAWN, 16'h0001, 0, 0);
    send_op(OP_SPAWN, 16'h8000, 0, 0);
    send_op(OP_RUN, 0, 1, 0);
    send_op(OP_RUN, 0, 1, 0);
    send_op(OP_SLEEP, 0, 0, 0);
    send_op(OP_SHUT, 0, 0, 0);

    // Single core: sleep fails, fill past the depth, shutdown.
    set_cores(1);
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      send_op(OP_SPAWN, TID_W'(i + 100), 0, i < QUEUE_DEPTH);
    send_op(OP_CAPQ, 0, 0, 0);
    send_op(OP_SLEEP, 0, 0, 0);
    send_op(OP_RUN, 0, 2, 0);
    send_op(OP_SHUT, 0, 0, 0);

    // Two cores full of work; sleeping one overflows the other.
    set_cores(2);
    for (int i = 0; i < 2 * QUEUE_DEPTH; i++)
      send_op(OP_SPAWN, TID_W'(i + 1), 0, i < 2 * QUEUE_DEPTH - 1);
    send_op(OP_RUN, 0, 0, 0);
    send_op(OP_SLEEP, 0, 1, 0);
    send_op(OP_SHUT, 0, 0, 0);

    stall_mode = 1;
    set_cores(4);
    random_ops(40);
    drain();
    stall_mode = 2;
    set_cores(0);
    random_ops(15);
    set_cores(7);
    random_ops(15);
    set_cores(3);
    stall_mode = 0;
    random_ops(15);
    stall_mode = 1;
    set_cores(4);
    random_ops(15);
    send_op(OP_SHUT, 0, 0, 0);

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("multicore_task_dispatcher_test: clean");
    end else begin
      $display("multicore_task_dispatcher_test: errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("multicore_task_dispatcher_test: errors");
    $finish;
  end

endmodule

// File: multicore_task_dispatcher.f
+incdir+hw/rtl
hw/rtl/mtd_pkg.sv
hw/rtl/mtd_ram.sv
hw/rtl/mtd_datapath.sv
hw/rtl/mtd_ctrl.sv
hw/rtl/multicore_task_dispatcher.sv
tb/sv/multicore_task_dispatcher_test.sv
